### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the trimmer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared widths, codes and control structs of the FASTQ end trimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package fte_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int T5_W       = 8;
    localparam int T3_W       = 6;
    localparam int DEST_W     = 2;
    localparam int SRC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_SLOTS  = 5;   // three before the ring drain, two after
    localparam int SLOT_IDX_W = 3;

    localparam logic [BYTE_W-1:0] NL_CHAR = 8'd10;
    localparam logic [POS_W-1:0]  POS_MAX = 16'hFFFF;

    // result destinations
    localparam logic [DEST_W-1:0] DEST_MAIN  = 2'd0;
    localparam logic [DEST_W-1:0] DEST_FIVE  = 2'd1;
    localparam logic [DEST_W-1:0] DEST_THREE = 2'd2;

    // byte source of a result slot
    localparam logic [SRC_W-1:0] SRC_BYTE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_NL   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_OLD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_5 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_3 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 2'd2;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [SRC_W-1:0]  src;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic pre_emit;
        logic drain_emit;
        logic post_emit;
    } cmd_t;

    typedef struct packed {
        logic pre_any;
        logic pre_one;
        logic drain_any;
        logic drain_one;
        logic post_any;
        logic post_one;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/fte_if.sv
// ----------------------------------------------------------------------------
// fte_if
// Valid/ready channels of the trimmer: text in, results out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fte_text_if;
    logic                      valid;
    logic                      ready;
    logic [fte_pkg::BYTE_W-1:0] in_byte;
    logic                      file_end;

    modport source (output valid, in_byte, file_end, input ready);
    modport sink   (input valid, in_byte, file_end, output ready);
endinterface

interface fte_result_if;
    logic                       valid;
    logic                       ready;
    logic [fte_pkg::DEST_W-1:0] dest;
    logic [fte_pkg::BYTE_W-1:0] out_byte;
    logic                       last_of_run;

    modport source (output valid, dest, out_byte, last_of_run, input ready);
    modport sink   (input valid, dest, out_byte, last_of_run, output ready);
endinterface

interface fte_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fte_pkg::CFG_IDX_W-1:0]  index;
    logic [fte_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/fastq_fixed_end_trimmer.sv
// ----------------------------------------------------------------------------
// fastq_fixed_end_trimmer
// Fixed-length 5'/3' trimming of FASTQ text streamed a byte per word.
//
//  channel  dir  payload                          handshake
//  -------  ---  -------------------------------  ---------------------
//  text     in   in_byte[7:0], file_end           valid/ready
//  result   out  dest[1:0], out_byte[7:0],        valid/ready
//                last_of_run
//  cfg      in   index[1:0], data[7:0]            valid/ready (ready=1)
//
// A text word is accepted only while the sequencer is idle; the next word waits
// until every result planned for it has left the sequencer. A trimmed line end
// gives, as enabled, the five-prime newline, the ring drain and the three-prime
// newline, then the main newline; the drain moves one tail byte per cycle.
// The single output register sets the pace: one result leaves per cycle while the
// result side is ready, and a stalled result side holds the sequencer.
// Reset clears line count, position, ring pointers and registers at once; the
// tail ring itself is not cleared, only bytes written in the current line are
// read back.
// ----------------------------------------------------------------------------
`default_nettype none

module fastq_fixed_end_trimmer #(
    parameter int MAX_TRIM_3 = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    fte_text_if.sink            text,
    fte_result_if.source        result,
    fte_cfg_if.sink             cfg
);

    fte_pkg::cmd_t cmd;
    fte_pkg::sts_t sts;

    // registers take a write in any cycle; writes are to be made only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    // controller: accept, then step through the planned results
    fte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: line state, tail ring, result plan, output register
    fte_datapath #(
        .MAX_TRIM_3 (MAX_TRIM_3)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .in_byte     (text.in_byte),
        .file_end    (text.file_end),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .dest        (result.dest),
        .out_byte    (result.out_byte),
        .last_of_run (result.last_of_run)
    );

endmodule

`default_nettype wire

### rtl/fte_ram.sv
// ----------------------------------------------------------------------------
// fte_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module fte_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/fte_ctrl.sv
// ----------------------------------------------------------------------------
// fte_ctrl
// Sequencer: accepts a word, then walks the leading results, the ring drain
// and the trailing results, one per cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fte_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fte_pkg::sts_t sts,
    output fte_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRE   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_POST  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] after_pre;
    logic [1:0] after_drain;

    assign in_ready    = (state_reg == ST_IDLE);
    assign after_pre   = sts.drain_any ? ST_DRAIN : (sts.post_any ? ST_POST : ST_IDLE);
    assign after_drain = sts.post_any ? ST_POST : ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (!sts.pre_any)
                begin
                    state_next = after_pre;
                end
                else if (sts.out_free)
                begin
                    cmd.pre_emit = 1'b1;
                    if (sts.pre_one)
                    begin
                        state_next = after_pre;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.drain_emit = 1'b1;
                    if (sts.drain_one)
                    begin
                        state_next = after_drain;
                    end
                end
            end
            ST_POST:
            begin
                if (!sts.post_any)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.post_emit = 1'b1;
                    if (sts.post_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    logic emit_any;
    assign emit_any = cmd.pre_emit || cmd.drain_emit || cmd.post_emit;

    `ASSERT_IMPL(a_emit_free, clk, rst_n, emit_any, sts.out_free)
    `ASSERT_IMPL(a_emit_single, clk, rst_n, 1'b1,
                 $onehot0({cmd.accept, cmd.pre_emit, cmd.drain_emit, cmd.post_emit}))
    `ASSERT_IMPL(a_drain_work, clk, rst_n, state_reg == ST_DRAIN, sts.drain_any)

endmodule

`default_nettype wire

### rtl/fte_datapath.sv
// ----------------------------------------------------------------------------
// fte_datapath
// Line state, tail ring, per-word result plan and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fte_datapath #(
    parameter int MAX_TRIM_3 = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [fte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fte_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fte_pkg::BYTE_W-1:0]       in_byte,
    input  logic                             file_end,
    input  fte_pkg::cmd_t                    cmd,
    output fte_pkg::sts_t                    sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fte_pkg::DEST_W-1:0]       dest,
    output logic [fte_pkg::BYTE_W-1:0]       out_byte,
    output logic                             last_of_run
);

    localparam int AW   = (MAX_TRIM_3 > 1) ? $clog2(MAX_TRIM_3) : 1;
    localparam int FW   = $clog2(MAX_TRIM_3 + 1);
    localparam int T3W  = fte_pkg::T3_W;
    localparam int CW   = (FW > T3W) ? FW : T3W;
    localparam int PW   = fte_pkg::POS_W;
    localparam int BW   = fte_pkg::BYTE_W;
    localparam int NS   = fte_pkg::NUM_SLOTS;
    localparam int SIW  = fte_pkg::SLOT_IDX_W;

    localparam logic [AW-1:0]  HEAD_LAST = AW'(MAX_TRIM_3 - 1);
    localparam logic [FW-1:0]  FILL_MAX  = FW'(MAX_TRIM_3);
    localparam logic [FW:0]    SUM_MOD   = (FW + 1)'(MAX_TRIM_3);
    localparam logic [T3W-1:0] T3_CAP    = T3W'(MAX_TRIM_3);

    // configuration
    logic [fte_pkg::T5_W-1:0] trim5_reg;
    logic [T3W-1:0]           trim3_reg;
    logic                     keep_reg;

    // line state
    logic [1:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg,   pos_next;
    logic [AW-1:0] head_reg,  head_next;
    logic [FW-1:0] fill_reg,  fill_next;

    // per-word plan
    logic [NS-1:0]     en_reg,        en_next;
    fte_pkg::slot_t    plan_reg [NS];
    fte_pkg::slot_t    plan_next [NS];
    logic [FW-1:0]     drain_cnt_reg, drain_cnt_next;
    logic [AW-1:0]     drain_ptr_reg, drain_ptr_next;
    logic [BW-1:0]     byte_reg;
    logic              fresh_reg;
    logic [BW-1:0]     old_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [fte_pkg::DEST_W-1:0]  out_dest_reg,  out_dest_next;
    logic [BW-1:0]               out_byte_reg,  out_byte_next;
    logic                        out_last_reg,  out_last_next;

    // ring
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    fte_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_TRIM_3)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decode of the incoming word against current line state
    logic [T3W-1:0] t3c;
    logic           k5, k3, seq, eol;
    logic           direct, pop, push, five_cut;
    logic [PW-1:0]  q;
    logic [FW-1:0]  fill_mid;
    logic [AW-1:0]  head_inc, head_mid, drain_ptr_inc;
    logic [FW:0]    wsum;
    logic [PW-1:0]  pos_inc;

    assign t3c      = (trim3_reg > T3_CAP) ? T3_CAP : trim3_reg;
    assign k5       = keep_reg && (trim5_reg != '0);
    assign k3       = keep_reg && (t3c != '0);
    assign seq      = phase_reg[0];
    assign eol      = (in_byte == fte_pkg::NL_CHAR) || file_end;
    assign five_cut = k5 && (pos_reg < PW'(trim5_reg));
    assign direct   = (fill_reg == '0) && (t3c == '0);
    assign pop      = !direct && (CW'(fill_reg) >= CW'(t3c)) && (fill_reg != '0);
    assign q        = (pos_reg >= PW'(fill_reg)) ? (pos_reg - PW'(fill_reg)) : '0;
    assign head_inc = (head_reg == HEAD_LAST) ? '0 : (head_reg + AW'(1));
    assign head_mid = pop ? head_inc : head_reg;
    assign fill_mid = pop ? (fill_reg - FW'(1)) : fill_reg;
    assign push     = !direct && (fill_mid < FILL_MAX);
    assign wsum     = (FW + 1)'(head_mid) + (FW + 1)'(fill_mid);
    assign ram_waddr = (wsum >= SUM_MOD) ? AW'(wsum - SUM_MOD) : AW'(wsum);
    assign ram_we   = cmd.accept && !eol && seq && push;
    assign pos_inc  = (pos_reg != fte_pkg::POS_MAX) ? (pos_reg + PW'(1)) : pos_reg;

    assign drain_ptr_inc = (drain_ptr_reg == HEAD_LAST) ? '0 : (drain_ptr_reg + AW'(1));
    // hold the read address on the next ring byte; the data arrives in the next cycle
    assign ram_raddr = cmd.accept     ? head_reg :
                       cmd.drain_emit ? drain_ptr_inc : drain_ptr_reg;

    // slot selection and status
    logic [SIW-1:0] pre_idx, post_idx;
    logic [BW-1:0]  old_byte;

    always_comb
    begin
        if (en_reg[0])
            pre_idx = SIW'(0);
        else if (en_reg[1])
            pre_idx = SIW'(1);
        else
            pre_idx = SIW'(2);
        post_idx = en_reg[3] ? SIW'(3) : SIW'(4);
    end

    assign old_byte      = fresh_reg ? ram_rdata : old_reg;
    assign sts.pre_any   = |en_reg[2:0];
    assign sts.pre_one   = ($countones(en_reg[2:0]) == 1);
    assign sts.drain_any = (drain_cnt_reg != '0);
    assign sts.drain_one = (drain_cnt_reg == FW'(1));
    assign sts.post_any  = |en_reg[4:3];
    assign sts.post_one  = ($countones(en_reg[4:3]) == 1);
    assign sts.out_free  = !out_valid_reg || out_ready;

    function automatic logic [BW-1:0] pick_byte(input logic [fte_pkg::SRC_W-1:0] src,
                                               input logic [BW-1:0] cur,
                                               input logic [BW-1:0] old);
        logic [BW-1:0] r;
        case (src)
            fte_pkg::SRC_BYTE: r = cur;
            fte_pkg::SRC_OLD:  r = old;
            default:           r = fte_pkg::NL_CHAR;
        endcase
        return r;
    endfunction

    // plan for the word being accepted
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            plan_next[i] = plan_reg[i];
        end
        en_next        = en_reg;
        drain_cnt_next = drain_cnt_reg;
        drain_ptr_next = drain_ptr_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;

        if (cmd.accept)
        begin
            for (int i = 0; i < NS; i++)
            begin
                plan_next[i] = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_NL};
            end
            en_next        = '0;
            drain_cnt_next = '0;
            drain_ptr_next = head_reg;

            if (eol)
            begin
                if (seq)
                begin
                    en_next[0]     = k5;
                    plan_next[0]   = '{dest: fte_pkg::DEST_FIVE, src: fte_pkg::SRC_NL};
                    drain_cnt_next = k3 ? fill_reg : '0;
                    en_next[3]     = k3;
                    plan_next[3]   = '{dest: fte_pkg::DEST_THREE, src: fte_pkg::SRC_NL};
                    en_next[4]     = 1'b1;
                    plan_next[4]   = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_NL};
                end
                else
                begin
                    en_next[0]   = 1'b1;
                    plan_next[0] = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_NL};
                    en_next[1]   = k5;
                    plan_next[1] = '{dest: fte_pkg::DEST_FIVE, src: fte_pkg::SRC_NL};
                    en_next[2]   = k3;
                    plan_next[2] = '{dest: fte_pkg::DEST_THREE, src: fte_pkg::SRC_NL};
                end
                pos_next   = '0;
                head_next  = '0;
                fill_next  = '0;
                phase_next = file_end ? 2'd0 : (phase_reg + 2'd1);
            end
            else if (seq)
            begin
                en_next[0]   = five_cut;
                plan_next[0] = '{dest: fte_pkg::DEST_FIVE, src: fte_pkg::SRC_BYTE};
                if (direct)
                begin
                    en_next[1]   = !(pos_reg < PW'(trim5_reg));
                    plan_next[1] = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_BYTE};
                end
                else
                begin
                    en_next[1]   = pop && (q >= PW'(trim5_reg));
                    plan_next[1] = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_OLD};
                end
                head_next = head_mid;
                fill_next = push ? (fill_mid + FW'(1)) : fill_mid;
                pos_next  = pos_inc;
            end
            else
            begin
                en_next[0]   = 1'b1;
                plan_next[0] = '{dest: fte_pkg::DEST_MAIN, src: fte_pkg::SRC_BYTE};
                en_next[1]   = k5;
                plan_next[1] = '{dest: fte_pkg::DEST_FIVE, src: fte_pkg::SRC_BYTE};
                en_next[2]   = k3;
                plan_next[2] = '{dest: fte_pkg::DEST_THREE, src: fte_pkg::SRC_BYTE};
                pos_next     = pos_inc;
            end
        end

        if (cmd.pre_emit)
        begin
            en_next[pre_idx] = 1'b0;
        end
        if (cmd.post_emit)
        begin
            en_next[post_idx] = 1'b0;
        end
        if (cmd.drain_emit)
        begin
            drain_cnt_next = drain_cnt_reg - FW'(1);
            drain_ptr_next = drain_ptr_inc;
        end
    end

    // output register load
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_dest_next  = out_dest_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.pre_emit)
        begin
            out_valid_next = 1'b1;
            out_dest_next  = plan_reg[pre_idx].dest;
            out_byte_next  = pick_byte(plan_reg[pre_idx].src, byte_reg, old_byte);
            out_last_next  = sts.pre_one && !sts.drain_any && !sts.post_any;
        end
        else if (cmd.drain_emit)
        begin
            out_valid_next = 1'b1;
            out_dest_next  = fte_pkg::DEST_THREE;
            out_byte_next  = ram_rdata;
            out_last_next  = 1'b0;
        end
        else if (cmd.post_emit)
        begin
            out_valid_next = 1'b1;
            out_dest_next  = plan_reg[post_idx].dest;
            out_byte_next  = pick_byte(plan_reg[post_idx].src, byte_reg, old_byte);
            out_last_next  = sts.post_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim5_reg     <= '0;
            trim3_reg     <= '0;
            keep_reg      <= 1'b0;
            phase_reg     <= '0;
            pos_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            en_reg        <= '0;
            drain_cnt_reg <= '0;
            drain_ptr_reg <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    fte_pkg::CFG_TRIM_5: trim5_reg <= cfg_data;
                    fte_pkg::CFG_TRIM_3: trim3_reg <= cfg_data[T3W-1:0];
                    fte_pkg::CFG_KEEP:   keep_reg  <= cfg_data[0];
                    default:             ;
                endcase
            end
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            en_reg        <= en_next;
            drain_cnt_reg <= drain_cnt_next;
            drain_ptr_reg <= drain_ptr_next;
            fresh_reg     <= cmd.accept;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            plan_reg[i] <= plan_next[i];
        end
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
        end
        // ring byte popped by the word just taken; the slot may be overwritten later
        if (fresh_reg)
        begin
            old_reg <= ram_rdata;
        end
        out_dest_reg <= out_dest_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign dest        = out_dest_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    `ASSERT_IMPL(a_head_range, clk, rst_n, 1'b1, head_reg <= HEAD_LAST)
    `ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= FILL_MAX)
    `ASSERT_NEXT(a_eol_clears, clk, rst_n, cmd.accept && eol,
                 (fill_reg == '0) && (pos_reg == '0) && (head_reg == '0))

endmodule

`default_nettype wire

### verif/tb_fastq_fixed_end_trimmer.sv
// ============================================================================
// tb_fastq_fixed_end_trimmer
// Self-checking bench for the FASTQ fixed-length end trimmer. FASTQ-shaped
// text is streamed in bursts while the result side stalls on its own pattern.
// A predictor tracks line count, position and tail ring and queues the result
// words each text word must cause; the monitor checks them in order. Several
// register settings are run, including the extremes, and one long sequence
// line with a full ring and a wide five-prime cut closes the run.
// ============================================================================
`timescale 1ns / 1ps

module tb_fastq_fixed_end_trimmer;

    localparam int RING_DEPTH  = 32;          // tail ring size of the instance
    localparam int CYCLE_LIMIT = 4_000_000;   // watchdog, far above a slow run
    localparam int LONG_LINE   = 64;          // well past the ring and the cut
    localparam int PHASE_WORDS = 35;          // text words per random phase

    localparam logic [fte_pkg::BYTE_W-1:0] CH_AT   = 8'h40;  // '@'
    localparam logic [fte_pkg::BYTE_W-1:0] CH_PLUS = 8'h2B;  // '+'

    typedef struct {
        logic [fte_pkg::BYTE_W-1:0] data;
        logic                       fe;
    } text_word_t;

    typedef struct packed {
        logic [fte_pkg::DEST_W-1:0] dest;
        logic [fte_pkg::BYTE_W-1:0] data;
        logic                       last;
    } out_word_t;

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fte_text_if   text_ch ();
    fte_result_if res_ch ();
    fte_cfg_if    cfg_ch ();

    fastq_fixed_end_trimmer #(
        .MAX_TRIM_3 (RING_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    text_word_t text_q[$];         // words waiting for the driver
    out_word_t  pending_out_q[$];  // predicted result words, oldest first

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  cfg_writes     = 0;
    int  lines_closed   = 0;
    int  errors         = 0;
    int  cycle_count    = 0;
    int  res_count[3]   = '{0, 0, 0};
    logic text_took = 1'b0;        // text word taken at the last rising edge
    logic cfg_took  = 1'b0;        // register write taken at the last rising edge
    logic [1:0] gen_line = 2'd0;   // line count as seen by the generator

    // predictor copy of registers and line state
    logic [fte_pkg::T5_W-1:0]   cut5     = '0;
    logic [fte_pkg::T3_W-1:0]   cut3     = '0;
    logic                       keep_en  = 1'b0;
    logic [1:0]                 rec_line = 2'd0;
    logic [fte_pkg::POS_W-1:0]  col      = '0;
    logic [fte_pkg::BYTE_W-1:0] tail_buf[RING_DEPTH];
    int                         tail_rd  = 0;
    int                         tail_cnt = 0;

    // driver / receiver pacing
    int burst_left = 0;
    int send_gap   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_hold    = 0;
    text_word_t next_word;
    out_word_t  want;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic out_word_t out_word(input logic [fte_pkg::DEST_W-1:0] d,
                                           input logic [fte_pkg::BYTE_W-1:0] b);
        out_word_t w;
        w.dest = d;
        w.data = b;
        w.last = 1'b0;
        return w;
    endfunction

    // Works out the result words of one accepted text word and queues them.
    function automatic void trim_predict(input logic [fte_pkg::BYTE_W-1:0] b,
                                         input logic fe);
        out_word_t got[$];
        int lim3, p, q, i;
        logic k5, k3, trimmed;
        logic [fte_pkg::BYTE_W-1:0] old;

        lim3    = (cut3 > RING_DEPTH) ? RING_DEPTH : int'(cut3);
        k5      = keep_en && (cut5 != 0);
        k3      = keep_en && (lim3 != 0);
        trimmed = rec_line[0];      // sequence and quality lines

        if (b == fte_pkg::NL_CHAR || fe) begin
            if (trimmed) begin
                // five-prime newline, ring drain + its newline, main newline
                if (k5)
                    got = {got, out_word(fte_pkg::DEST_FIVE, fte_pkg::NL_CHAR)};
                if (k3) begin
                    for (i = 0; i < tail_cnt; i++)
                        got = {got, out_word(fte_pkg::DEST_THREE,
                                             tail_buf[(tail_rd + i) % RING_DEPTH])};
                    got = {got, out_word(fte_pkg::DEST_THREE, fte_pkg::NL_CHAR)};
                end
                got = {got, out_word(fte_pkg::DEST_MAIN, fte_pkg::NL_CHAR)};
            end
            else begin
                got = {got, out_word(fte_pkg::DEST_MAIN, fte_pkg::NL_CHAR)};
                if (k5)
                    got = {got, out_word(fte_pkg::DEST_FIVE, fte_pkg::NL_CHAR)};
                if (k3)
                    got = {got, out_word(fte_pkg::DEST_THREE, fte_pkg::NL_CHAR)};
            end
            col      = '0;
            tail_rd  = 0;
            tail_cnt = 0;
            rec_line = fe ? 2'd0 : rec_line + 2'd1;
        end
        else if (trimmed) begin
            p = int'(col);
            if (k5 && p < cut5)
                got = {got, out_word(fte_pkg::DEST_FIVE, b)};
            if (tail_cnt == 0 && lim3 == 0) begin
                if (p >= cut5)
                    got = {got, out_word(fte_pkg::DEST_MAIN, b)};
            end
            else begin
                // ring full for the current delay: oldest byte leaves
                if (tail_cnt >= lim3 && tail_cnt > 0) begin
                    old      = tail_buf[tail_rd];
                    q        = (p >= tail_cnt) ? p - tail_cnt : 0;
                    tail_rd  = (tail_rd + 1) % RING_DEPTH;
                    tail_cnt = tail_cnt - 1;
                    if (q >= cut5)
                        got = {got, out_word(fte_pkg::DEST_MAIN, old)};
                end
                if (tail_cnt < RING_DEPTH) begin
                    tail_buf[(tail_rd + tail_cnt) % RING_DEPTH] = b;
                    tail_cnt = tail_cnt + 1;
                end
            end
            if (col != fte_pkg::POS_MAX)
                col = col + 1'b1;
        end
        else begin
            // header and plus lines are copied to every enabled output
            got = {got, out_word(fte_pkg::DEST_MAIN, b)};
            if (k5)
                got = {got, out_word(fte_pkg::DEST_FIVE, b)};
            if (k3)
                got = {got, out_word(fte_pkg::DEST_THREE, b)};
            if (col != fte_pkg::POS_MAX)
                col = col + 1'b1;
        end

        if (got.size() > 0)
            got[got.size() - 1].last = 1'b1;
        pending_out_q = {pending_out_q, got};
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // monitor: everything sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            cfg_took  <= cfg_ch.valid && cfg_ch.ready;
            text_took <= text_ch.valid && text_ch.ready;

            // results of earlier words checked before this edge's word is predicted
            if (res_ch.valid && res_ch.ready) begin
                if (res_ch.dest <= fte_pkg::DEST_THREE)
                    res_count[res_ch.dest]++;
                if (pending_out_q.size() == 0) begin
                    flag_error($sformatf("unexpected result dest %0d byte 0x%02h last %0b",
                                         res_ch.dest, res_ch.out_byte, res_ch.last_of_run));
                end
                else begin
                    want = pending_out_q.pop_front();
                    if (res_ch.dest !== want.dest || res_ch.out_byte !== want.data
                        || res_ch.last_of_run !== want.last)
                        flag_error($sformatf({"result mismatch: want dest %0d byte 0x%02h ",
                                              "last %0b, got dest %0d byte 0x%02h last %0b"},
                                             want.dest, want.data, want.last, res_ch.dest,
                                             res_ch.out_byte, res_ch.last_of_run));
                end
            end

            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    fte_pkg::CFG_TRIM_5: cut5    = cfg_ch.data[fte_pkg::T5_W-1:0];
                    fte_pkg::CFG_TRIM_3: cut3    = cfg_ch.data[fte_pkg::T3_W-1:0];
                    fte_pkg::CFG_KEEP:   keep_en = cfg_ch.data[0];
                    default: ;
                endcase
            end

            if (text_ch.valid && text_ch.ready) begin
                words_accepted++;
                if (text_ch.in_byte == fte_pkg::NL_CHAR || text_ch.file_end)
                    lines_closed++;
                trim_predict(text_ch.in_byte, text_ch.file_end);
            end
        end
    end

    // ------------------------------------------------------------------------
    // text driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!text_ch.valid || text_took)) begin
            if (send_gap > 0) begin
                text_ch.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (text_q.size() > 0) begin
                next_word = text_q.pop_front();
                text_ch.valid    <= 1'b1;
                text_ch.in_byte  <= next_word.data;
                text_ch.file_end <= next_word.fe;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts run straight into the next one
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else begin
                text_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: switches between always ready, coin flip, mostly
    // ready, and short hard stalls
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 1) == 1);
            2: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_hold > 0) begin
                    res_ch.ready <= 1'b0;
                    rx_hold = rx_hold - 1;
                end
                else begin
                    res_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_out_q.size());
            $display("tb_fastq_fixed_end_trimmer failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [fte_pkg::BYTE_W-1:0] b, input logic fe);
        text_word_t w;
        w.data = b;
        w.fe   = fe;
        text_q = {text_q, w};
        words_queued++;
        if (fe)
            gen_line = 2'd0;
        else if (b == fte_pkg::NL_CHAR)
            gen_line = gen_line + 2'd1;
    endtask

    task automatic queue_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_word(s[i], 1'b0);
        queue_word(fte_pkg::NL_CHAR, 1'b0);
    endtask

    // any byte but newline
    function automatic logic [fte_pkg::BYTE_W-1:0] text_byte();
        int v;
        v = $urandom_range(0, 254);
        if (v >= fte_pkg::NL_CHAR)
            v++;
        return v[fte_pkg::BYTE_W-1:0];
    endfunction

    // Waits for every word to be taken and every result to arrive, then
    // lets the block settle.
    task automatic wait_idle(input int settle);
        @(negedge clk);
        while (words_accepted != words_queued || pending_out_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [fte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fte_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_trim(input int t5, input int t3, input int keep);
        wait_idle(10);   // a word that only fills the ring leaves no result behind
        cfg_write(fte_pkg::CFG_TRIM_5, t5[fte_pkg::CFG_DATA_W-1:0]);
        cfg_write(fte_pkg::CFG_TRIM_3, t3[fte_pkg::CFG_DATA_W-1:0]);
        cfg_write(fte_pkg::CFG_KEEP, keep[fte_pkg::CFG_DATA_W-1:0]);
    endtask

    // Mostly well-formed lines following the current line count, with lone
    // noise bytes (newline included) and early file ends mixed in. Phases end on a
    // line end unless a noise byte came last, which leaves the next setting mid-line.
    task automatic queue_random_phase(input int n_words);
        int start, len, i, lim3;
        start = words_queued;
        lim3  = (cut3 > RING_DEPTH) ? RING_DEPTH : int'(cut3);
        while (words_queued - start < n_words) begin
            if ($urandom_range(0, 15) == 0) begin
                queue_word(8'($urandom_range(0, 255)), 1'b0);
            end
            else begin
                if (gen_line[0]) begin
                    // now and then a line at or just past the length that reaches the main output
                    if ($urandom_range(0, 9) == 0)
                        len = cut5 + lim3 + $urandom_range(0, 6);
                    else
                        len = $urandom_range(0, 14);
                end
                else begin
                    queue_word((gen_line == 2'd0) ? CH_AT : CH_PLUS, 1'b0);
                    len = $urandom_range(0, 5);
                end
                for (i = 0; i < len; i++)
                    queue_word(text_byte(), 1'b0);
                if ($urandom_range(0, 24) == 0)
                    queue_word(8'($urandom_range(0, 255)), 1'b1);
                else
                    queue_word(fte_pkg::NL_CHAR, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;

        text_ch.valid    = 1'b0;
        text_ch.in_byte  = '0;
        text_ch.file_end = 1'b0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: copied and trimmed lines, byte extremes, empty line,
        // file end on a plain byte and on a newline
        set_trim(2, 3, 1);
        queue_word(CH_AT, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(fte_pkg::NL_CHAR, 1'b0);
        queue_word("A", 1'b0);
        queue_word("C", 1'b0);
        queue_word("G", 1'b0);
        queue_word("T", 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word("A", 1'b0);
        queue_word(fte_pkg::NL_CHAR, 1'b0);
        queue_line("+");
        queue_word(fte_pkg::NL_CHAR, 1'b0);     // empty quality line
        queue_line("@");
        queue_word("G", 1'b0);
        queue_word("C", 1'b0);
        queue_word("T", 1'b1);                  // file ends mid sequence line
        queue_word(CH_AT, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(fte_pkg::NL_CHAR, 1'b1);     // file ends on a header newline
        queue_line("@");
        queue_word("N", 1'b0);

        // random phases, extremes first
        set_trim(0, 0, 0);
        queue_random_phase(PHASE_WORDS);
        set_trim(0, 0, 1);
        queue_random_phase(PHASE_WORDS);
        set_trim(4, 3, 1);
        queue_random_phase(PHASE_WORDS);
        set_trim(255, 32, 1);
        queue_random_phase(PHASE_WORDS);
        set_trim(1, 32, 0);
        queue_random_phase(PHASE_WORDS);
        set_trim(0, 5, 1);
        queue_random_phase(PHASE_WORDS);
        set_trim(7, 0, 1);
        queue_random_phase(PHASE_WORDS);
        set_trim($urandom_range(0, 12), $urandom_range(0, 32), $urandom_range(0, 1));
        queue_random_phase(PHASE_WORDS);
        set_trim($urandom_range(0, 12), $urandom_range(0, 32), 1);
        queue_random_phase(PHASE_WORDS);
        set_trim(3, 63, 1);                     // above the ring size: clamps
        queue_random_phase(PHASE_WORDS);

        // one sequence line that fills the ring and outruns the five-prime cut
        set_trim(20, 32, 1);
        queue_word("Z", 1'b1);                  // close whatever line is open
        queue_line("@");
        for (i = 0; i < LONG_LINE; i++)
            queue_word(text_byte(), 1'b0);
        queue_word(fte_pkg::NL_CHAR, 1'b0);
        queue_line("+");
        queue_word("#", 1'b1);

        wait_idle(40);
        if (pending_out_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_out_q.size()));

        $display("ran %0d text words over %0d lines with %0d register writes",
                 words_accepted, lines_closed, cfg_writes);
        $display("checked results: main %0d, five-prime %0d, three-prime %0d, errors %0d",
                 res_count[0], res_count[1], res_count[2], errors);
        if (errors == 0)
            $display("tb_fastq_fixed_end_trimmer passed");
        else
            $display("tb_fastq_fixed_end_trimmer failed");
        $finish;
    end

endmodule
